>>> hdl/rept_pkg.sv
// Package: shared codes and constants for the rotary encoder position tracker.
`timescale 1ns / 1ps

package rept_pkg;

  // Decoded 2-bit pin state of the encoder
  typedef enum logic [1:0] {
    ST_REST = 2'h0,  // detent position, completes a step while armed
    ST_CW   = 2'h1,  // clockwise quarter
    ST_ARM  = 2'h2,  // arms the detector
    ST_CCW  = 2'h3   // counter-clockwise quarter
  } qstate_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_STEP_COUNT  = 2'd0,
    REG_WRAP_ENABLE = 2'd1,
    REG_GRAY_DECODE = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_e;

  // Field widths fixed by the interface
  localparam int unsigned StepW  = 16;
  localparam int unsigned InW    = 8;   // pin_a, pin_b, padded to a byte
  localparam int unsigned OutW   = 24;  // position, stepped, ccw, padded
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // Reset values of the configuration registers
  localparam logic [StepW-1:0] StepCountRst = 16'd240;
  localparam logic             WrapRst      = 1'b1;
  localparam logic             GrayRst      = 1'b1;

endpackage

>>> hdl/rotary_encoder_position_tracker.sv
// Top level: quadrature encoder full-period decoder with position tracking.
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tdata[0] pin_a, tdata[1] pin_b
//   m_axis    out        m_axis_tvalid/tready       tdata[15:0] position,
//                                                   [16] stepped, [17] ccw
//   cfg       in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One item per clock while the output is free and, in wrap mode, the remainder
// cache is valid; each result appears in the cycle after its item is taken.
// In wrap mode the position is reduced modulo step_count from a cached
// remainder. After a step_count write, or when the position is left at or
// above a nonzero step_count, a shift-subtract remainder unit refreshes that
// cache (set directly when the position is already below it or step_count is
// zero); wrap mode items wait for it. Saturate mode items never wait for it.
// Reset is asynchronous, active low, and sets the state registers to defaults.
// A stalled result holds in the output register and blocks the input until taken.
`timescale 1ns / 1ps

module rotary_encoder_position_tracker
  import rept_pkg::*;
#(
  parameter int unsigned POS_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item in: [0] pin_a, [1] pin_b, [7:2] zero
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InW-1:0]     s_axis_tdata,
  // result out: [15:0] position, [16] stepped, [17] counter_clockwise, [23:18] zero
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OutW-1:0]    m_axis_tdata,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(POS_BITS + 1);

  // Configuration registers
  logic [StepW-1:0] steps_q, steps_d;
  logic             wrap_q, wrap_d;
  logic             gray_q, gray_d;

  // Tracker state
  logic                armed_q, armed_d;
  logic                ccw_q, ccw_d;
  logic [POS_BITS-1:0] pos_q, pos_d;

  // Cached remainder of the position modulo step_count
  logic [StepW-1:0] mod_q, mod_d;
  logic             mod_ok_q, mod_ok_d;

  // Remainder unit
  logic                div_busy_q, div_busy_d;
  logic [CntW-1:0]     div_cnt_q, div_cnt_d;
  logic [POS_BITS-1:0] div_num_q, div_num_d;
  logic [StepW-1:0]    div_rem_q, div_rem_d;
  logic [StepW:0]      div_try;
  logic [StepW-1:0]    div_rem_nxt;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [StepW-1:0] out_pos_q, out_pos_d;
  logic             out_step_q, out_step_d;
  logic             out_ccw_q, out_ccw_d;

  // Handshakes and item decode
  logic          in_fire, cfg_fire, step_wr;
  logic          pin_a, pin_b;
  qstate_e       qst;
  logic          do_step;
  logic          pos_below;
  logic [POS_BITS-1:0] pos_wrap, pos_sat, pos_new;
  logic [StepW:0]      mod_inc;
  logic [StepW-1:0]    wrap_res;

  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i;
  assign step_wr       = cfg_fire && (reg_idx_e'(cfg_index_i) == REG_STEP_COUNT);
  assign s_axis_tready = (!out_valid_q || m_axis_tready) && (!wrap_q || mod_ok_q);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign pin_a = s_axis_tdata[0];
  assign pin_b = s_axis_tdata[1] ^ (pin_a & gray_q);
  assign qst   = qstate_e'({pin_a, pin_b});

  assign pos_below = (33'(pos_q) < 33'(steps_q));

  // Wrap step from the cached remainder
  assign mod_inc = 17'(mod_q) + 17'd1;
  always_comb begin
    if (steps_q == '0) begin
      wrap_res = '0;
    end else if (ccw_q) begin
      wrap_res = (mod_q == '0) ? steps_q - 16'd1 : mod_q - 16'd1;
    end else begin
      wrap_res = (mod_inc == 17'(steps_q)) ? '0 : mod_inc[StepW-1:0];
    end
  end
  assign pos_wrap = POS_BITS'(32'(wrap_res));

  // Saturating step
  always_comb begin
    if (ccw_q) begin
      pos_sat = (pos_q != '0) ? pos_q - POS_BITS'(1) : pos_q;
    end else begin
      pos_sat = pos_below ? pos_q + POS_BITS'(1) : pos_q;
    end
  end
  assign pos_new = wrap_q ? pos_wrap : pos_sat;

  // Detector: arm, latch direction, complete detent
  always_comb begin
    armed_d = armed_q;
    ccw_d   = ccw_q;
    do_step = 1'b0;
    if (in_fire) begin
      unique case (qst)
        ST_REST: begin
          if (armed_q) begin
            do_step = 1'b1;
            armed_d = 1'b0;
          end
        end
        ST_CW:   if (armed_q) ccw_d = 1'b0;
        ST_CCW:  if (armed_q) ccw_d = 1'b1;
        ST_ARM:  armed_d = 1'b1;
        default: armed_d = armed_q;
      endcase
    end
  end

  assign pos_d = do_step ? pos_new : pos_q;

  // One shift-subtract step of the remainder unit
  assign div_try     = {div_rem_q, div_num_q[POS_BITS-1]};
  assign div_rem_nxt = (div_try >= 17'(steps_q)) ? StepW'(div_try - 17'(steps_q))
                                                 : div_try[StepW-1:0];

  // Remainder cache and its refresh
  always_comb begin
    mod_d      = mod_q;
    mod_ok_d   = mod_ok_q;
    div_busy_d = div_busy_q;
    div_cnt_d  = div_cnt_q;
    div_num_d  = div_num_q;
    div_rem_d  = div_rem_q;
    if (div_busy_q) begin
      div_num_d = div_num_q << 1;
      div_rem_d = div_rem_nxt;
      div_cnt_d = div_cnt_q - CntW'(1);
      if (div_cnt_q == CntW'(1)) begin
        div_busy_d = 1'b0;
        mod_d      = div_rem_nxt;
        mod_ok_d   = 1'b1;
      end
    end else if (!mod_ok_q) begin
      if (steps_q == '0 || pos_below) begin
        mod_d    = (steps_q == '0) ? '0 : StepW'(32'(pos_q));
        mod_ok_d = 1'b1;
      end else begin
        div_busy_d = 1'b1;
        div_cnt_d  = CntW'(POS_BITS);
        div_num_d  = pos_q;
        div_rem_d  = '0;
      end
    end
    // a moved position drops any refresh in flight; zero modulus keeps a zero remainder
    if (do_step) begin
      div_busy_d = 1'b0;
      if (steps_q == '0 || 33'(pos_new) < 33'(steps_q)) begin
        mod_d    = (steps_q == '0) ? '0 : StepW'(32'(pos_new));
        mod_ok_d = 1'b1;
      end else begin
        mod_ok_d = 1'b0;
      end
    end
    if (step_wr) begin
      div_busy_d = 1'b0;
      mod_ok_d   = 1'b0;
    end
  end

  // Configuration writes
  always_comb begin
    steps_d = steps_q;
    wrap_d  = wrap_q;
    gray_d  = gray_q;
    if (cfg_fire) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_STEP_COUNT:  steps_d = cfg_data_i;
        REG_WRAP_ENABLE: wrap_d  = cfg_data_i[0];
        REG_GRAY_DECODE: gray_d  = cfg_data_i[0];
        default:         steps_d = steps_q;
      endcase
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;
    out_step_d  = out_step_q;
    out_ccw_d   = out_ccw_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      out_pos_d   = StepW'(32'(pos_d));
      out_step_d  = do_step;
      out_ccw_d   = ccw_d;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_ccw_q, out_step_q, out_pos_q};

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q     <= StepCountRst;
      wrap_q      <= WrapRst;
      gray_q      <= GrayRst;
      armed_q     <= 1'b0;
      ccw_q       <= 1'b0;
      pos_q       <= '0;
      mod_q       <= '0;
      mod_ok_q    <= 1'b1;
      div_busy_q  <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      steps_q     <= steps_d;
      wrap_q      <= wrap_d;
      gray_q      <= gray_d;
      armed_q     <= armed_d;
      ccw_q       <= ccw_d;
      pos_q       <= pos_d;
      mod_q       <= mod_d;
      mod_ok_q    <= mod_ok_d;
      div_busy_q  <= div_busy_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    div_num_q  <= div_num_d;
    div_rem_q  <= div_rem_d;
    out_pos_q  <= out_pos_d;
    out_step_q <= out_step_d;
    out_ccw_q  <= out_ccw_d;
  end

`ifndef SYNTH
  // wrap mode only takes items with a valid remainder cache
  a_wrap_needs_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && wrap_q) |-> mod_ok_q)
    else $error("wrap item accepted with stale remainder");

  // a valid cached remainder lies below a nonzero modulus
  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_ok_q && steps_q != '0) |-> (mod_q < steps_q))
    else $error("cached remainder out of range");

  // the remainder unit only runs while the cache is stale
  a_busy_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> !mod_ok_q)
    else $error("remainder unit busy with valid cache");

  // a new modulus always invalidates the cache
  a_wr_invalidates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_wr |=> !mod_ok_q)
    else $error("cache not invalidated by step_count write");
`endif

endmodule
